@@ rtl/lvrp_pkg.sv @@
`default_nettype none
package lvrp_pkg;

  // Field keys reported with each result
  typedef enum logic [3:0] {
    KEY_UNKNOWN  = 4'd0,
    KEY_CURRENT  = 4'd1,
    KEY_PANEL_V  = 4'd2,
    KEY_PANEL_P  = 4'd3,
    KEY_CHG_ST   = 4'd4,
    KEY_ERROR    = 4'd5,
    KEY_H19      = 4'd6,
    KEY_PROD_ID  = 4'd7,
    KEY_SERIAL   = 4'd8,
    KEY_VOLTAGE  = 4'd9
  } key_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] DEC_NONE    = 2'd0;
  localparam logic [1:0] DEC_CURRENT = 2'd2;
  localparam logic [1:0] DEC_VOLTAGE = 2'd3;

  // One result transaction
  typedef struct packed {
    key_t        field_key;
    logic [31:0] field_value;
    logic [1:0]  decimal_places;
    logic        value_saturated;
  } result_t;

  // Match the label suffix in priority order
  function automatic key_t match_label(input logic [31:0] w);
    key_t k;
    k = KEY_UNKNOWN;
    if (w[7:0] == 8'h49)                k = KEY_CURRENT;
    else if (w[23:0] == 24'h565056)     k = KEY_PANEL_V;
    else if (w[23:0] == 24'h505056)     k = KEY_PANEL_P;
    else if (w[15:0] == 16'h4353)       k = KEY_CHG_ST;
    else if (w[23:0] == 24'h455252)     k = KEY_ERROR;
    else if (w[23:0] == 24'h483139)     k = KEY_H19;
    else if (w[23:0] == 24'h504944)     k = KEY_PROD_ID;
    else if (w == 32'h53455223)         k = KEY_SERIAL;
    else if (w[7:0] == 8'h56)           k = KEY_VOLTAGE;
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lvrp_ifs.sv @@
`default_nettype none
// Byte input channel
interface lvrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Parsed field result channel
interface lvrp_out_if import lvrp_pkg::*;;
  logic               valid;
  logic               ready;
  key_t               field_key;
  logic signed [31:0] field_value;
  logic [1:0]         decimal_places;
  logic               value_saturated;
  modport source (output valid, output field_key, output field_value,
                  output decimal_places, output value_saturated, input ready);
  modport sink (input valid, input field_key, input field_value,
                input decimal_places, input value_saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/label_value_record_parser_top.sv @@
`default_nettype none
// Label/value text record parser. Takes one byte per clock on in_ch and parses
// records of the form LABEL<TAB>value<CR>. At CR a result (key, integer value,
// implied decimal places, saturation flag) appears on out_ch in the cycle after the
// CR transaction when the result register is free, later while an earlier result
// still waits; numeric fields with no digits or an out-of-range CS value give
// no result. Every byte is handled in the cycle it is accepted, so the block
// sustains one byte per cycle; a result register plus one skid entry keep input
// flowing while a result waits, and input stalls only when both are full.
module label_value_record_parser_top import lvrp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  lvrp_in_if.sink      in_ch,
  lvrp_out_if.source   out_ch
);

  localparam int VW    = VALUE_WIDTH;
  localparam int EXT_W = (VW > 32) ? VW : 32;

  localparam logic [VW-1:0] CAP     = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] CAP_M1  = {1'b0, {(VW-1){1'b1}}};

  // Record state
  logic [31:0]   window_r, window_nxt;
  logic          tab_r, tab_nxt;
  key_t          key_r, key_nxt;
  logic          sign_r, sign_nxt;
  logic          neg_r, neg_nxt;
  logic          digits_r, digits_nxt;
  logic          ended_r, ended_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;

  // Output register and skid entry
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;

  logic    in_fire, out_fire, emit;
  result_t res;
  logic    res_valid;

  logic [7:0]    b;
  logic          is_digit;
  logic [VW+3:0] acc_x10;
  logic [VW-1:0] mag;
  logic          sat;
  logic signed [VW-1:0]    val;
  logic signed [EXT_W-1:0] val_ext;
  key_t          cr_key;

  assign b        = in_ch.rx_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // Next accumulator value: acc*10 + digit in widened form
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                 + {{(VW){1'b0}}, 4'(b - CH_ZERO)};

  // Build the result for a CR byte
  always_comb begin
    cr_key    = tab_r ? key_r : KEY_UNKNOWN;
    mag       = acc_r;
    sat       = ovf_r;
    if (!neg_r && (acc_r > CAP_M1)) begin
      mag = CAP_M1;
      sat = 1'b1;
    end
    val       = neg_r ? signed'(VW'(-acc_r)) : signed'(mag);
    val_ext   = EXT_W'(val);
    res_valid = 1'b1;
    res.field_key       = cr_key;
    res.field_value     = val_ext[31:0];
    res.value_saturated = sat;
    res.decimal_places  = DEC_NONE;
    if (cr_key == KEY_UNKNOWN || cr_key == KEY_PROD_ID || cr_key == KEY_SERIAL) begin
      res.field_value     = '0;
      res.value_saturated = 1'b0;
    end else if (!digits_r) begin
      res_valid = 1'b0;
    end else begin
      if (cr_key == KEY_CHG_ST &&
          (sat || (neg_r && (mag != '0)) || (mag > VW'(2)))) begin
        res_valid = 1'b0;
      end
      if (cr_key == KEY_PANEL_V || cr_key == KEY_VOLTAGE) begin
        res.decimal_places = DEC_VOLTAGE;
      end else if (cr_key == KEY_CURRENT || cr_key == KEY_H19) begin
        res.decimal_places = DEC_CURRENT;
      end
    end
  end

  assign emit = in_fire && (b == CH_CR) && res_valid;

  // Record state update for one byte
  always_comb begin
    window_nxt = window_r;
    tab_nxt    = tab_r;
    key_nxt    = key_r;
    sign_nxt   = sign_r;
    neg_nxt    = neg_r;
    digits_nxt = digits_r;
    ended_nxt  = ended_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    if (in_fire) begin
      if (b == CH_CR) begin
        window_nxt = '0;
        tab_nxt    = 1'b0;
        key_nxt    = KEY_UNKNOWN;
        sign_nxt   = 1'b0;
        neg_nxt    = 1'b0;
        digits_nxt = 1'b0;
        ended_nxt  = 1'b0;
        acc_nxt    = '0;
        ovf_nxt    = 1'b0;
      end else if (!tab_r) begin
        if (b == CH_TAB) begin
          tab_nxt = 1'b1;
          key_nxt = match_label(window_r);
        end else begin
          window_nxt = {window_r[23:0], b};
        end
      end else if (b < CH_SPACE || ended_r) begin
        // skip control bytes and anything after the number
      end else if (is_digit) begin
        digits_nxt = 1'b1;
        if (acc_x10 > {4'b0, CAP}) begin
          acc_nxt = CAP;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_x10[VW-1:0];
        end
      end else if (!sign_r && !digits_r && b == CH_SPACE) begin
        // drop leading space
      end else if (!sign_r && !digits_r && b == CH_MINUS) begin
        sign_nxt = 1'b1;
        neg_nxt  = 1'b1;
      end else begin
        ended_nxt = 1'b1;
      end
    end
  end

  // Output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (emit) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      tab_r        <= 1'b0;
      key_r        <= KEY_UNKNOWN;
      sign_r       <= 1'b0;
      neg_r        <= 1'b0;
      digits_r     <= 1'b0;
      ended_r      <= 1'b0;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      tab_r        <= tab_nxt;
      key_r        <= key_nxt;
      sign_r       <= sign_nxt;
      neg_r        <= neg_nxt;
      digits_r     <= digits_nxt;
      ended_r      <= ended_nxt;
      acc_r        <= acc_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ch.ready            = !skid_valid_r;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.field_key       = out_data_r.field_key;
  assign out_ch.field_value     = signed'(out_data_r.field_value);
  assign out_ch.decimal_places  = out_data_r.decimal_places;
  assign out_ch.value_saturated = out_data_r.value_saturated;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
  import lvrp_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 64;
  localparam int RANDOM_BYTES = 1180;
  localparam logic [63:0] MAG_CAP = 64'h8000_0000;

  // One directed record: text with stand-in characters and an optional typed result
  typedef struct {
    string   txt;
    bit      typed;
    bit      gives;
    result_t res;
  } row_t;

  logic clk;
  logic rst_n;

  lvrp_in_if  in_if();
  lvrp_out_if out_if();

  label_value_record_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  int      mismatches = 0;
  int      bytes_sent = 0;
  int      stall_cycles = 0;
  int      hold_req = 0;
  int      hold_done = 0;
  int      hold_left = 0;
  bit      calm = 1'b0;
  bit      typed_row = 1'b0;
  bit      typed_gives = 1'b0;
  result_t typed_res;
  result_t expected_fields[$];

  // Parser state mirrored from the record rules
  logic [31:0] win;
  bit          past_tab;
  key_t        cur_key;
  bit          minus_seen;
  bit          neg;
  bit          got_digit;
  bit          num_done;
  logic [63:0] mag;
  bit          mag_clamped;

  // Clock and initial drive of every input
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_record();
    win = '0;
    past_tab = 1'b0;
    cur_key = KEY_UNKNOWN;
    minus_seen = 1'b0;
    neg = 1'b0;
    got_digit = 1'b0;
    num_done = 1'b0;
    mag = '0;
    mag_clamped = 1'b0;
  endfunction

  // Label suffix lookup, first hit wins
  function automatic key_t label_key(input logic [31:0] w);
    if (w[7:0] == "I") return KEY_CURRENT;
    if (w[23:0] == "VPV") return KEY_PANEL_V;
    if (w[23:0] == "PPV") return KEY_PANEL_P;
    if (w[15:0] == "CS") return KEY_CHG_ST;
    if (w[23:0] == "ERR") return KEY_ERROR;
    if (w[23:0] == "H19") return KEY_H19;
    if (w[23:0] == "PID") return KEY_PROD_ID;
    if (w == "SER#") return KEY_SERIAL;
    if (w[7:0] == "V") return KEY_VOLTAGE;
    return KEY_UNKNOWN;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result
  function automatic bit predict_byte(input logic [7:0] b, output result_t r);
    key_t        k;
    logic [63:0] m;
    logic [63:0] d;
    bit          got;
    bit          sat;
    r = '0;
    got = 1'b0;
    if (b == CH_CR) begin
      k = past_tab ? cur_key : KEY_UNKNOWN;
      got = 1'b1;
      r.field_key = k;
      if (k == KEY_UNKNOWN || k == KEY_PROD_ID || k == KEY_SERIAL) begin
        r.field_value = '0;
      end else if (!got_digit) begin
        got = 1'b0;
      end else begin
        m = mag;
        sat = mag_clamped;
        if (neg) begin
          r.field_value = 32'd0 - m[31:0];
        end else begin
          if (m > MAG_CAP - 1) begin
            m = MAG_CAP - 1;
            sat = 1'b1;
          end
          r.field_value = m[31:0];
        end
        // charger state only takes 0..2
        if (k == KEY_CHG_ST && (sat || (neg && m != 0) || m > 2)) got = 1'b0;
        if (k == KEY_PANEL_V || k == KEY_VOLTAGE) r.decimal_places = DEC_VOLTAGE;
        else if (k == KEY_CURRENT || k == KEY_H19) r.decimal_places = DEC_CURRENT;
        else r.decimal_places = DEC_NONE;
        r.value_saturated = sat;
      end
      clear_record();
    end else if (!past_tab) begin
      if (b == CH_TAB) begin
        past_tab = 1'b1;
        cur_key = label_key(win);
      end else begin
        win = {win[23:0], b};
      end
    end else if (b < CH_SPACE || num_done) begin
      // skip control bytes and everything after the number
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      d = 64'(b - CH_ZERO);
      got_digit = 1'b1;
      if (mag > (MAG_CAP - d) / 10) begin
        mag = MAG_CAP;
        mag_clamped = 1'b1;
      end else begin
        mag = mag * 10 + d;
      end
    end else if (!minus_seen && !got_digit && b == CH_SPACE) begin
      // leading space
    end else if (!minus_seen && !got_digit && b == CH_MINUS) begin
      minus_seen = 1'b1;
      neg = 1'b1;
    end else begin
      num_done = 1'b1;
    end
    return got;
  endfunction

  // Offer one byte, idling at random, and record the expected result on acceptance
  task automatic send_byte(input logic [7:0] b);
    result_t r;
    bit      got;
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    got = predict_byte(b, r);
    if (typed_row) begin
      if (b == CH_CR && typed_gives) expected_fields = {expected_fields, typed_res};
    end else if (got) begin
      expected_fields = {expected_fields, r};
    end
    bytes_sent++;
  endtask

  // Stand-ins: '>' TAB, ';' CR, '@' 0x01, '!' 0x00, '%' 0xFF
  task automatic send_text(input string txt);
    logic [7:0] c;
    for (int i = 0; i < txt.len(); i++) begin
      c = txt[i];
      case (c)
        ">": c = CH_TAB;
        ";": c = CH_CR;
        "@": c = 8'h01;
        "!": c = 8'h00;
        "%": c = 8'hFF;
        default: ;
      endcase
      send_byte(c);
    end
  endtask

  function automatic row_t text_row(input string txt, input bit typed = 1'b0,
                                    input bit gives = 1'b0, input key_t k = KEY_UNKNOWN,
                                    input logic [31:0] v = '0,
                                    input logic [1:0] dp = DEC_NONE,
                                    input logic s = 1'b0);
    row_t row;
    row.txt = txt;
    row.typed = typed;
    row.gives = gives;
    row.res.field_key = k;
    row.res.field_value = v;
    row.res.decimal_places = dp;
    row.res.value_saturated = s;
    return row;
  endfunction

  // Mostly well-formed records with random content, some broken, some noise
  task automatic random_record();
    logic [7:0] seq[$];
    string      lbl;
    string      pool;
    int         kind;
    int         ndig;
    int         pick;
    logic [7:0] c;
    pool = "IVPCSERH19D#";
    lbl = "";
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) seq = {seq, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 1)) seq = {seq, CH_CR};
    end else begin
      repeat ($urandom_range(0, 2)) seq = {seq, 8'($urandom_range(8'h21, 8'h7E))};
      case ($urandom_range(0, 10))
        0: lbl = "I";
        1: lbl = "VPV";
        2: lbl = "PPV";
        3: lbl = "CS";
        4: lbl = "ERR";
        5: lbl = "H19";
        6: lbl = "PID";
        7: lbl = "SER#";
        8: lbl = "V";
        default: repeat ($urandom_range(1, 4)) seq = {seq, pool[$urandom_range(0, 11)]};
      endcase
      for (int i = 0; i < lbl.len(); i++) seq = {seq, lbl[i]};
      // drop the TAB on a few records
      if (kind >= 15) seq = {seq, CH_TAB};
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) seq = {seq, CH_SPACE};
      if ($urandom_range(0, 3) == 0) seq = {seq, CH_MINUS};
      pick = $urandom_range(0, 99);
      if (lbl == "CS") ndig = (pick < 8) ? 0 : 1;
      else if (pick < 8) ndig = 0;
      else if (pick < 88) ndig = $urandom_range(1, 6);
      else ndig = $urandom_range(7, 14);
      repeat (ndig) begin
        if ($urandom_range(0, 24) == 0) begin
          c = 8'($urandom_range(0, 31));
          seq = {seq, (c == CH_CR) ? CH_TAB : c};
        end
        if (lbl == "CS") seq = {seq, 8'(CH_ZERO + $urandom_range(0, 3))};
        else seq = {seq, 8'(CH_ZERO + $urandom_range(0, 9))};
      end
      // trailing text that the number end swallows
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) seq = {seq, 8'($urandom_range(8'h20, 8'hFF))};
      end
      seq = {seq, CH_CR};
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Hold the input until every expected result has come, then let the block settle
  task automatic drain(input int settle);
    in_if.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic check_result();
    result_t e;
    if (expected_fields.size() == 0) begin
      $error("result with nothing expected: key %0d value %0d",
             out_if.field_key, out_if.field_value);
      mismatches++;
    end else begin
      e = expected_fields.pop_front();
      if (out_if.field_key !== e.field_key) begin
        $error("field_key: expected %0d, got %0d", e.field_key, out_if.field_key);
        mismatches++;
      end
      if (out_if.field_value !== e.field_value) begin
        $error("field_value: expected %0d, got %0d", $signed(e.field_value),
               out_if.field_value);
        mismatches++;
      end
      if (out_if.decimal_places !== e.decimal_places) begin
        $error("decimal_places: expected %0d, got %0d", e.decimal_places,
               out_if.decimal_places);
        mismatches++;
      end
      if (out_if.value_saturated !== e.value_saturated) begin
        $error("value_saturated: expected %0b, got %0b", e.value_saturated,
               out_if.value_saturated);
        mismatches++;
      end
    end
  endtask

  // Check each result transaction and drive ready, with one long hold on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) check_result();
      if (hold_left == 0 && hold_req != hold_done) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done++;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    int   recs;
    int   first_random;
    clear_record();
    rows = {rows, text_row("I>1234;", 1, 1, KEY_CURRENT, 32'd1234, DEC_CURRENT)};
    rows = {rows, text_row("V>-12800;", 1, 1, KEY_VOLTAGE, -32'sd12800, DEC_VOLTAGE)};
    rows = {rows, text_row("VPV>  18500;")};
    rows = {rows, text_row("PPV>2147483647;", 1, 1, KEY_PANEL_P, 32'h7FFF_FFFF)};
    rows = {rows, text_row("PPV>2147483648;", 1, 1, KEY_PANEL_P, 32'h7FFF_FFFF,
                           DEC_NONE, 1'b1)};
    rows = {rows, text_row("I>-2147483648;", 1, 1, KEY_CURRENT, 32'h8000_0000,
                           DEC_CURRENT)};
    rows = {rows, text_row("I>-99999999999;", 1, 1, KEY_CURRENT, 32'h8000_0000,
                           DEC_CURRENT, 1'b1)};
    rows = {rows, text_row("CS>3;", 1, 0)};
    rows = {rows, text_row("CS>-1;", 1, 0)};
    rows = {rows, text_row("CS>-0;")};
    rows = {rows, text_row("CS>2;", 1, 1, KEY_CHG_ST, 32'd2)};
    rows = {rows, text_row("ERR>;", 1, 0)};
    rows = {rows, text_row("H19>12x34;")};
    rows = {rows, text_row("PID>0xA043;")};
    rows = {rows, text_row("SER#>HQ1234;")};
    rows = {rows, text_row("XYZ>55;", 1, 1, KEY_UNKNOWN, 32'd0)};
    rows = {rows, text_row(";", 1, 1, KEY_UNKNOWN, 32'd0)};
    rows = {rows, text_row("V>1@2>3;")};
    rows = {rows, text_row("V>- 5;", 1, 0)};
    rows = {rows, text_row("V>+5;", 1, 0)};
    rows = {rows, text_row("V>--5;", 1, 0)};
    rows = {rows, text_row("!%I>7;")};
    rows = {rows, text_row("VERR>5;")};
    rows = {rows, text_row("ABVPV>3;")};
    rows = {rows, text_row("I> -0042 x9;")};

    // Release reset
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (rows[i]) begin
      typed_row = rows[i].typed;
      typed_gives = rows[i].gives;
      typed_res = rows[i].res;
      send_text(rows[i].txt);
    end
    typed_row = 1'b0;
    drain(8);

    // Stall the result side while short records keep coming in
    hold_req++;
    calm = 1'b1;
    repeat (4) begin
      send_text("I>5;");
      send_text("V>-12;");
      send_text("CS>1;");
    end
    calm = 1'b0;
    drain(8);

    // Random records, with one long stretch without idling
    recs = 0;
    first_random = bytes_sent;
    while (bytes_sent - first_random < RANDOM_BYTES) begin
      calm = (recs >= 60 && recs < 110);
      random_record();
      recs++;
    end
    calm = 1'b0;
    drain(16);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
